// ----- hw/rtl/ybgr_pkg.sv -----
`default_nettype none

package ybgr_pkg;

    localparam int MAX_PAIRS_PER_ROW_DEF = 2048;
    localparam int MAX_ROWS_DEF          = 4096;

    localparam int PIX_W     = 8;
    localparam int PAIRS_W   = 12;
    localparam int ROWS_W    = 13;
    localparam int COEFF_W   = 12;
    localparam int ADDR_W    = 23;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;
    localparam int DELTA_W   = 22;
    localparam int SUM_W     = 23;

    localparam logic [PAIRS_W-1:0] PAIRS_RST     = 12'd320;
    localparam logic [ROWS_W-1:0]  ROWS_RST      = 13'd480;
    localparam logic [COEFF_W-1:0] RED_V_RST     = 12'd1436;
    localparam logic [COEFF_W-1:0] GREEN_U_RST   = 12'd352;
    localparam logic [COEFF_W-1:0] GREEN_V_RST   = 12'd731;
    localparam logic [COEFF_W-1:0] BLUE_U_RST    = 12'd1815;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAIRS_PER_ROW    = 3'd0,
        CFG_ROWS_PER_FRAME   = 3'd1,
        CFG_RED_FROM_V       = 3'd2,
        CFG_GREEN_FROM_U     = 3'd3,
        CFG_GREEN_FROM_V     = 3'd4,
        CFG_BLUE_FROM_U      = 3'd5
    } t_cfg_idx;

    typedef logic signed [DELTA_W-1:0] t_delta;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } t_bgr;

    typedef struct packed {
        t_bgr              left;
        t_bgr              right;
        logic [ADDR_W-1:0] pair_address;
        logic              frame_end;
    } t_result;

    function automatic logic [PIX_W-1:0] to_byte(input logic signed [SUM_W-1:0] sum);
        logic [PIX_W-1:0] res;
        if (sum < 0) begin
            res = '0;
        end else if (sum[SUM_W-1:PIX_W+10] != '0) begin
            res = '1;
        end else begin
            res = sum[PIX_W+9:10];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ybgr_pixel.sv -----
`default_nettype none

module ybgr_pixel (
    input  wire logic [ybgr_pkg::PIX_W-1:0] i_y,
    input  wire ybgr_pkg::t_delta           i_db,
    input  wire ybgr_pkg::t_delta           i_dg,
    input  wire ybgr_pkg::t_delta           i_dr,
    output ybgr_pkg::t_bgr                  o_pix
);
    import ybgr_pkg::*;

    logic signed [SUM_W-1:0] y_q10;
    logic signed [SUM_W-1:0] sum_b;
    logic signed [SUM_W-1:0] sum_g;
    logic signed [SUM_W-1:0] sum_r;

    assign y_q10 = $signed({{(SUM_W-PIX_W-10){1'b0}}, i_y, 10'b0});
    assign sum_b = y_q10 + SUM_W'(i_db);
    assign sum_g = y_q10 + SUM_W'(i_dg);
    assign sum_r = y_q10 + SUM_W'(i_dr);

    assign o_pix.blue  = to_byte(sum_b);
    assign o_pix.green = to_byte(sum_g);
    assign o_pix.red   = to_byte(sum_r);

endmodule

`default_nettype wire

// ----- hw/rtl/ybgr_addr_gen.sv -----
`default_nettype none

module ybgr_addr_gen #(
    parameter int MAX_PAIRS_PER_ROW = ybgr_pkg::MAX_PAIRS_PER_ROW_DEF,
    parameter int MAX_ROWS          = ybgr_pkg::MAX_ROWS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_advance,
    input  wire logic [ybgr_pkg::PAIRS_W-1:0]  i_pairs_per_row,
    input  wire logic [ybgr_pkg::ROWS_W-1:0]   i_rows_per_frame,
    output logic      [ybgr_pkg::ADDR_W-1:0]   o_pair_address,
    output logic                               o_frame_end
);
    import ybgr_pkg::*;

    localparam int COL_W  = (MAX_PAIRS_PER_ROW > 1) ? $clog2(MAX_PAIRS_PER_ROW) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int PL_W   = $clog2(MAX_PAIRS_PER_ROW + 1);
    localparam int RL_W   = $clog2(MAX_ROWS + 1);
    localparam int PROD_W = PL_W + RL_W + 1;
    localparam int AS_W   = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    logic [PL_W-1:0]  pairs, pairs_m1;
    logic [RL_W-1:0]  rows, rows_m1;
    logic [COL_W-1:0] col_eff;
    logic [ROW_W-1:0] row_eff;
    logic             last_col, last_row;
    logic [AS_W-1:0]  addr_sum;

    always_comb begin
        if (i_pairs_per_row == '0) begin
            pairs = PL_W'(1);
        end else if (32'(i_pairs_per_row) > 32'(MAX_PAIRS_PER_ROW)) begin
            pairs = PL_W'(MAX_PAIRS_PER_ROW);
        end else begin
            pairs = PL_W'(i_pairs_per_row);
        end
        if (i_rows_per_frame == '0) begin
            rows = RL_W'(1);
        end else if (32'(i_rows_per_frame) > 32'(MAX_ROWS)) begin
            rows = RL_W'(MAX_ROWS);
        end else begin
            rows = RL_W'(i_rows_per_frame);
        end
    end

    assign pairs_m1 = pairs - PL_W'(1);
    assign rows_m1  = rows - RL_W'(1);
    assign col_eff  = (32'(r_col) >= 32'(pairs)) ? COL_W'(pairs_m1) : r_col;
    assign row_eff  = (32'(r_row) >= 32'(rows)) ? ROW_W'(rows_m1) : r_row;
    assign last_col = (32'(col_eff) == 32'(pairs_m1));
    assign last_row = (32'(row_eff) == 32'(rows_m1));

    assign addr_sum = AS_W'(rows_m1 - RL_W'(row_eff)) * AS_W'(pairs) + AS_W'(col_eff);
    assign o_pair_address = addr_sum[ADDR_W-1:0];
    assign o_frame_end    = last_col & last_row;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_advance) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : row_eff + ROW_W'(1);
            end else begin
                n_col = col_eff + COL_W'(1);
                n_row = row_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/yuyv_to_bgr888_converter.sv -----
// YUYV 4:2:2 to BGR888 pixel-pair converter.
// The input channel (i_valid, o_stall) carries one YUYV macropixel per
// transfer: two luma samples and the shared U and V samples.
// The output channel (o_valid, i_stall) carries two BGR888 pixels per
// transfer, with the bottom-up pixel-pair address and a frame-end flag.
// The four Q10 chroma gains and the frame geometry are written through
// i_cfg_we, i_cfg_index and i_cfg_data; the user must do so only while
// the block is idle, since the block itself does not enforce it.
// Multipliers, adders and clamps are combinational and feed the output
// register; one macropixel per cycle passes while no stall holds the flow.
// A one-entry skid register sits beside the output register, so o_stall
// is a register and rises only when an input is taken while the receiver
// holds i_stall with a result waiting; no result is lost or repeated.
// Synchronous reset empties both registers, restores the default gains and
// a 640x480 geometry, and sets the row and column counters to zero.
`default_nettype none

module yuyv_to_bgr888_converter #(
    parameter int MAX_PAIRS_PER_ROW = ybgr_pkg::MAX_PAIRS_PER_ROW_DEF,
    parameter int MAX_ROWS          = ybgr_pkg::MAX_ROWS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [ybgr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ybgr_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [ybgr_pkg::PIX_W-1:0]      i_luma_first,
    input  wire logic [ybgr_pkg::PIX_W-1:0]      i_chroma_u,
    input  wire logic [ybgr_pkg::PIX_W-1:0]      i_luma_second,
    input  wire logic [ybgr_pkg::PIX_W-1:0]      i_chroma_v,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic      [ybgr_pkg::PIX_W-1:0]      o_blue_left,
    output logic      [ybgr_pkg::PIX_W-1:0]      o_green_left,
    output logic      [ybgr_pkg::PIX_W-1:0]      o_red_left,
    output logic      [ybgr_pkg::PIX_W-1:0]      o_blue_right,
    output logic      [ybgr_pkg::PIX_W-1:0]      o_green_right,
    output logic      [ybgr_pkg::PIX_W-1:0]      o_red_right,
    output logic      [ybgr_pkg::ADDR_W-1:0]     o_pair_address,
    output logic                                 o_frame_end
);
    import ybgr_pkg::*;

    localparam int PROD_W = PIX_W + COEFF_W + 1;

    logic [PAIRS_W-1:0] r_pairs_per_row;
    logic [ROWS_W-1:0]  r_rows_per_frame;
    logic [COEFF_W-1:0] r_red_v, r_green_u, r_green_v, r_blue_u;

    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result result;

    logic                      accept;
    logic                      out_free;
    logic signed [PIX_W-1:0]   uc, vc;
    logic signed [PROD_W-1:0]  p_rv, p_gu, p_gv, p_bu;
    t_delta                    dr, dg, db;
    logic [ADDR_W-1:0]         addr;
    logic                      frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pairs_per_row  <= PAIRS_RST;
            r_rows_per_frame <= ROWS_RST;
            r_red_v          <= RED_V_RST;
            r_green_u        <= GREEN_U_RST;
            r_green_v        <= GREEN_V_RST;
            r_blue_u         <= BLUE_U_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PAIRS_PER_ROW:  r_pairs_per_row  <= i_cfg_data[PAIRS_W-1:0];
                CFG_ROWS_PER_FRAME: r_rows_per_frame <= i_cfg_data[ROWS_W-1:0];
                CFG_RED_FROM_V:     r_red_v          <= i_cfg_data[COEFF_W-1:0];
                CFG_GREEN_FROM_U:   r_green_u        <= i_cfg_data[COEFF_W-1:0];
                CFG_GREEN_FROM_V:   r_green_v        <= i_cfg_data[COEFF_W-1:0];
                CFG_BLUE_FROM_U:    r_blue_u         <= i_cfg_data[COEFF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign accept   = i_valid & ~r_skid_valid;
    assign out_free = ~r_out_valid | ~i_stall;

    assign uc = $signed({~i_chroma_u[PIX_W-1], i_chroma_u[PIX_W-2:0]});
    assign vc = $signed({~i_chroma_v[PIX_W-1], i_chroma_v[PIX_W-2:0]});

    assign p_rv = PROD_W'(vc) * $signed({1'b0, r_red_v});
    assign p_gu = PROD_W'(uc) * $signed({1'b0, r_green_u});
    assign p_gv = PROD_W'(vc) * $signed({1'b0, r_green_v});
    assign p_bu = PROD_W'(uc) * $signed({1'b0, r_blue_u});

    assign dr = DELTA_W'(p_rv);
    assign db = DELTA_W'(p_bu);
    assign dg = -DELTA_W'(p_gu) - DELTA_W'(p_gv);

    ybgr_pixel u_pixel_left (
        .i_y   (i_luma_first),
        .i_db  (db),
        .i_dg  (dg),
        .i_dr  (dr),
        .o_pix (result.left)
    );

    ybgr_pixel u_pixel_right (
        .i_y   (i_luma_second),
        .i_db  (db),
        .i_dg  (dg),
        .i_dr  (dr),
        .o_pix (result.right)
    );

    ybgr_addr_gen #(
        .MAX_PAIRS_PER_ROW (MAX_PAIRS_PER_ROW),
        .MAX_ROWS          (MAX_ROWS)
    ) u_addr_gen (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (accept),
        .i_pairs_per_row  (r_pairs_per_row),
        .i_rows_per_frame (r_rows_per_frame),
        .o_pair_address   (addr),
        .o_frame_end      (frame_end)
    );

    assign result.pair_address = addr;
    assign result.frame_end    = frame_end;

    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (accept) begin
                n_out       = result;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (accept) begin
            n_skid       = result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_stall        = r_skid_valid;
    assign o_valid        = r_out_valid;
    assign o_blue_left    = r_out.left.blue;
    assign o_green_left   = r_out.left.green;
    assign o_red_left     = r_out.left.red;
    assign o_blue_right   = r_out.right.blue;
    assign o_green_right  = r_out.right.green;
    assign o_red_right    = r_out.right.red;
    assign o_pair_address = r_out.pair_address;
    assign o_frame_end    = r_out.frame_end;

endmodule

`default_nettype wire
